@@ rtl/afld_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afld_pkg
// Shared widths, register map, control codes and types for the audio front
// end level tracker and demodulator sample feed.
// ----------------------------------------------------------------------------
package afld_pkg;

  // Item field widths.
  localparam int STREAM_IDX_W = 3;
  localparam int SAMPLE_W     = 16;
  localparam int DEMOD_W      = 17;
  localparam int LEVEL_W      = 8;

  // Configuration register widths.
  localparam int MODE_W   = 2;
  localparam int FACTOR_W = 4;
  localparam int COEFF_W  = 16;

  // Per-stream state widths.
  localparam int TRACK_W = 25;
  localparam int SUM_W   = 20;
  localparam int CNT_W   = 4;

  // A tracker holds the sample scaled up by this many bits.
  localparam int TRACK_FRAC_SHIFT = 8;
  // Half of one Q0.16 unit, used to round the tracker step.
  localparam int COEFF_ROUND = 32768;

  // Level = floor((peak - valley) * 50 / 2^22 + 1/2), clamped.
  localparam int LEVEL_GAIN  = 50;
  localparam int LEVEL_SHIFT = 22;
  localparam int LEVEL_ROUND = 2097152;
  localparam int LEVEL_MAX   = 200;

  // Default parameter values.
  localparam int DEF_NUM_STREAMS     = 8;
  localparam int DEF_UPSAMPLE_FACTOR = 2;

  // APB port.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  // Register indexes (byte address is four times the index).
  localparam logic [REG_IDX_W-1:0] REG_MODEM_MODE      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DECIMATE_FACTOR = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ATTACK_COEFF    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_DECAY_COEFF     = 2'd3;

  // Modem mode codes. Code 3 behaves as baseband.
  localparam logic [MODE_W-1:0] MODE_OFF      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_AFSK     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BASEBAND = 2'd2;

  // Register reset values.
  localparam logic [MODE_W-1:0]   RST_MODEM_MODE      = MODE_OFF;
  localparam logic [FACTOR_W-1:0] RST_DECIMATE_FACTOR = 4'd1;
  localparam logic [COEFF_W-1:0]  RST_ATTACK_COEFF    = 16'd6554;
  localparam logic [COEFF_W-1:0]  RST_DECAY_COEFF     = 16'd66;

  typedef struct packed {
    logic [MODE_W-1:0]   modem_mode;
    logic [FACTOR_W-1:0] decimate_factor;
    logic [COEFF_W-1:0]  attack_coeff;
    logic [COEFF_W-1:0]  decay_coeff;
  } cfg_t;

  // One word of per-stream state memory.
  typedef struct packed {
    logic [TRACK_W-1:0] peak;
    logic [TRACK_W-1:0] valley;
    logic [SUM_W-1:0]   sum;
    logic [CNT_W-1:0]   cnt;
  } state_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_PMUL,
    S_PADD,
    S_VMUL,
    S_VADD,
    S_LEVEL,
    S_DECIM,
    S_DIV,
    S_WRITE,
    S_EMIT
  } afld_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD,
    OP_PMUL,
    OP_PADD,
    OP_VMUL,
    OP_VADD,
    OP_LEVEL,
    OP_DECIM,
    OP_DIV,
    OP_WRITE,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic decim_hit;
    logic div_last;
    logic emit_last;
    logic out_free;
  } dp_status_t;

  // Index width for a count of entries, at least one bit.
  function automatic int idx_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage
`default_nettype wire

@@ rtl/afld_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afld_ifs
// Valid/ready channels for sample items in and result items out.
// ----------------------------------------------------------------------------
interface afld_in_if;
  logic                                valid;
  logic                                ready;
  logic [afld_pkg::STREAM_IDX_W-1:0]   stream_index;
  logic signed [afld_pkg::SAMPLE_W-1:0] audio_sample;

  modport source(output valid, output stream_index, output audio_sample, input ready);
  modport sink(input valid, input stream_index, input audio_sample, output ready);
endinterface

interface afld_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 sample_valid;
  logic signed [afld_pkg::DEMOD_W-1:0]  demod_sample;
  logic [afld_pkg::LEVEL_W-1:0]         received_level;
  logic                                 last_of_run;

  modport source(output valid, output sample_valid, output demod_sample,
                 output received_level, output last_of_run, input ready);
  modport sink(input valid, input sample_valid, input demod_sample,
               input received_level, input last_of_run, output ready);
endinterface
`default_nettype wire

@@ rtl/afld_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afld_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module afld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [afld_pkg::idx_width(DEPTH)-1:0]     waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [afld_pkg::idx_width(DEPTH)-1:0]     raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/afld_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afld_regs
// APB configuration registers shared by all streams.
// ----------------------------------------------------------------------------
module afld_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [afld_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [afld_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [afld_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output afld_pkg::cfg_t                    cfg
);
  import afld_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.modem_mode      <= RST_MODEM_MODE;
      cfg.decimate_factor <= RST_DECIMATE_FACTOR;
      cfg.attack_coeff    <= RST_ATTACK_COEFF;
      cfg.decay_coeff     <= RST_DECAY_COEFF;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MODEM_MODE:      cfg.modem_mode      <= pwdata[MODE_W-1:0];
        REG_DECIMATE_FACTOR: cfg.decimate_factor <= pwdata[FACTOR_W-1:0];
        REG_ATTACK_COEFF:    cfg.attack_coeff    <= pwdata[COEFF_W-1:0];
        REG_DECAY_COEFF:     cfg.decay_coeff     <= pwdata[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODEM_MODE:      prdata = APB_DATA_W'(cfg.modem_mode);
      REG_DECIMATE_FACTOR: prdata = APB_DATA_W'(cfg.decimate_factor);
      REG_ATTACK_COEFF:    prdata = APB_DATA_W'(cfg.attack_coeff);
      REG_DECAY_COEFF:     prdata = APB_DATA_W'(cfg.decay_coeff);
      default:             prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/afld_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afld_ctrl
// Sequencer: steps one item through state read, tracker updates, level,
// decimation and divide, state write-back and result emission.
// ----------------------------------------------------------------------------
module afld_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  afld_pkg::cfg_t          cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  afld_pkg::dp_status_t    status,
  output afld_pkg::dp_cmd_t       cmd
);
  import afld_pkg::*;

  afld_state_t state, state_next;
  logic        afsk_decim;

  assign afsk_decim = (cfg.modem_mode == MODE_AFSK) && (cfg.decimate_factor > 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_CAPTURE;
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.op     = OP_LOAD;
        state_next = S_PMUL;
      end
      S_PMUL: begin
        cmd.op     = OP_PMUL;
        state_next = S_PADD;
      end
      S_PADD: begin
        cmd.op     = OP_PADD;
        state_next = S_VMUL;
      end
      S_VMUL: begin
        cmd.op     = OP_VMUL;
        state_next = S_VADD;
      end
      S_VADD: begin
        cmd.op     = OP_VADD;
        state_next = S_LEVEL;
      end
      S_LEVEL: begin
        cmd.op     = OP_LEVEL;
        state_next = afsk_decim ? S_DECIM : S_WRITE;
      end
      S_DECIM: begin
        cmd.op     = OP_DECIM;
        state_next = status.decim_hit ? S_DIV : S_WRITE;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (status.div_last) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.op     = OP_WRITE;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op = OP_EMIT;
          if (status.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/afld_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afld_dp
// Datapath: item capture, shared tracker multiplier, level scaling, boxcar
// sum with a bit-serial divider, result formatting and the output register.
// ----------------------------------------------------------------------------
module afld_dp #(
  parameter int NUM_STREAMS     = afld_pkg::DEF_NUM_STREAMS,
  parameter int UPSAMPLE_FACTOR = afld_pkg::DEF_UPSAMPLE_FACTOR
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  afld_pkg::cfg_t                                cfg,
  input  afld_pkg::dp_cmd_t                             cmd,
  input  logic [afld_pkg::STREAM_IDX_W-1:0]             in_stream_index,
  input  logic signed [afld_pkg::SAMPLE_W-1:0]          in_audio_sample,
  output afld_pkg::dp_status_t                          status,
  output logic                                          ram_we,
  output logic [afld_pkg::idx_width(NUM_STREAMS)-1:0]   ram_addr,
  output afld_pkg::state_word_t                         ram_wdata,
  input  afld_pkg::state_word_t                         ram_rdata,
  input  logic                                          out_ready,
  output logic                                          out_valid,
  output logic                                          out_sample_valid,
  output logic signed [afld_pkg::DEMOD_W-1:0]           out_demod_sample,
  output logic [afld_pkg::LEVEL_W-1:0]                  out_received_level,
  output logic                                          out_last_of_run
);
  import afld_pkg::*;

  localparam int IDX_W     = idx_width(NUM_STREAMS);
  localparam int EM_W      = idx_width(UPSAMPLE_FACTOR);
  localparam int DIV_CNT_W = $clog2(SUM_W);
  localparam int X_W       = TRACK_W + 1;
  localparam int PROD_W    = X_W + COEFF_W + 1;
  localparam int EXT_W     = X_W - SAMPLE_W - TRACK_FRAC_SHIFT;

  // Item and per-stream working registers.
  logic [IDX_W-1:0]             idx_r;
  logic signed [SAMPLE_W-1:0]   sam_r;
  logic signed [TRACK_W-1:0]    peak_r;
  logic signed [TRACK_W-1:0]    valley_r;
  logic signed [SUM_W-1:0]      sum_r;
  logic [CNT_W-1:0]             cnt_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic [LEVEL_W-1:0]           level_r;
  logic                         hit_r;
  logic                         div_neg;
  logic [SUM_W-1:0]             div_quot;
  logic [FACTOR_W-1:0]          div_rem;
  logic [DIV_CNT_W-1:0]         div_cnt;
  logic [EM_W-1:0]              em_cnt;
  logic [NUM_STREAMS-1:0]       written_r;

  logic signed [X_W-1:0]        x_ext;
  logic signed [X_W-1:0]        peak_ext;
  logic signed [X_W-1:0]        valley_ext;
  logic signed [X_W-1:0]        cur_ext;
  logic                         use_peak;
  logic                         toward;
  logic signed [COEFF_W:0]      coeff_s;
  logic signed [X_W-1:0]        diff_x;
  logic signed [PROD_W-1:0]     prod_full;
  logic signed [PROD_W-1:0]     step;
  logic signed [TRACK_W-1:0]    track_new;
  logic signed [X_W-1:0]        lvl_diff;
  logic signed [31:0]           lvl_prod;
  logic signed [31:0]           lvl_round;
  logic [LEVEL_W-1:0]           lvl_clamp;
  logic signed [SUM_W-1:0]      sum_new;
  logic [CNT_W-1:0]             cnt_new;
  logic [SUM_W-1:0]             sum_mag;
  logic [FACTOR_W:0]            rem_sh;
  logic [FACTOR_W+1:0]          trial;
  logic                         trial_ge;
  logic [SUM_W-1:0]             avg;
  logic signed [31:0]           up_full;
  logic                         res_valid;
  logic signed [DEMOD_W-1:0]    res_sample;
  logic                         emit_last;

  // Stream index modulo the stream count by repeated subtraction.
  function automatic logic [IDX_W-1:0] reduce_idx(input logic [STREAM_IDX_W-1:0] raw);
    logic [STREAM_IDX_W:0] v;
    v = {1'b0, raw};
    for (int i = 0; i < 2**STREAM_IDX_W; i++) begin
      if (v >= NUM_STREAMS) begin
        v = v - (STREAM_IDX_W+1)'(NUM_STREAMS);
      end
    end
    return IDX_W'(v);
  endfunction

  // Tracker step: t + floor((coeff * (x - t) + 2^15) / 2^16).
  assign x_ext      = {{EXT_W{sam_r[SAMPLE_W-1]}}, sam_r, {TRACK_FRAC_SHIFT{1'b0}}};
  assign peak_ext   = X_W'(peak_r);
  assign valley_ext = X_W'(valley_r);
  assign use_peak   = (cmd.op == OP_PMUL) || (cmd.op == OP_PADD);
  assign cur_ext    = use_peak ? peak_ext : valley_ext;
  assign toward     = use_peak ? (x_ext >= peak_ext) : (x_ext <= valley_ext);
  assign coeff_s    = $signed({1'b0, toward ? cfg.attack_coeff : cfg.decay_coeff});
  assign diff_x     = x_ext - cur_ext;
  assign prod_full  = diff_x * coeff_s;
  assign step       = (prod_r + PROD_W'(COEFF_ROUND)) >>> COEFF_W;
  assign track_new  = TRACK_W'(cur_ext + X_W'(step));

  // Level scaling with round to nearest, then clamp.
  assign lvl_diff  = peak_ext - valley_ext;
  assign lvl_prod  = 32'(lvl_diff) * LEVEL_GAIN;
  assign lvl_round = (lvl_prod + LEVEL_ROUND) >>> LEVEL_SHIFT;

  always_comb begin
    if (lvl_round < 0) begin
      lvl_clamp = '0;
    end else if (lvl_round > LEVEL_MAX) begin
      lvl_clamp = LEVEL_W'(LEVEL_MAX);
    end else begin
      lvl_clamp = LEVEL_W'(lvl_round);
    end
  end

  // Boxcar accumulate and the divider's restoring step.
  assign sum_new  = sum_r + SUM_W'(sam_r);
  assign cnt_new  = cnt_r + CNT_W'(1);
  assign sum_mag  = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
  assign rem_sh   = {div_rem, div_quot[SUM_W-1]};
  assign trial    = {1'b0, rem_sh} - {2'b00, cfg.decimate_factor};
  assign trial_ge = !trial[FACTOR_W+1];
  assign avg      = div_neg ? SUM_W'(-div_quot) : div_quot;
  assign up_full  = 32'(sam_r) * UPSAMPLE_FACTOR;

  assign status.decim_hit = (cnt_new >= cfg.decimate_factor);
  assign status.div_last  = (div_cnt == DIV_CNT_W'(SUM_W - 1));
  assign status.out_free  = !out_valid || out_ready;
  assign status.emit_last = emit_last;

  always_comb begin
    emit_last  = 1'b1;
    res_valid  = 1'b0;
    res_sample = '0;
    case (cfg.modem_mode)
      MODE_OFF: begin
        res_valid = 1'b0;
      end
      MODE_AFSK: begin
        if (cfg.decimate_factor > 4'd1) begin
          res_valid  = hit_r;
          res_sample = hit_r ? DEMOD_W'(avg) : '0;
        end else begin
          res_valid  = 1'b1;
          res_sample = DEMOD_W'(sam_r);
        end
      end
      default: begin
        // Baseband: zeros first, then the sample scaled by UPSAMPLE_FACTOR.
        emit_last  = (em_cnt == EM_W'(UPSAMPLE_FACTOR - 1));
        res_valid  = 1'b1;
        res_sample = emit_last ? DEMOD_W'(up_full) : '0;
      end
    endcase
  end

  assign ram_we           = (cmd.op == OP_WRITE);
  assign ram_addr         = idx_r;
  assign ram_wdata.peak   = peak_r;
  assign ram_wdata.valley = valley_r;
  assign ram_wdata.sum    = sum_r;
  assign ram_wdata.cnt    = cnt_r;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        idx_r  <= reduce_idx(in_stream_index);
        sam_r  <= in_audio_sample;
        em_cnt <= '0;
        hit_r  <= 1'b0;
      end
      OP_LOAD: begin
        // A stream never written since reset reads as all zero.
        if (written_r[idx_r]) begin
          peak_r   <= $signed(ram_rdata.peak);
          valley_r <= $signed(ram_rdata.valley);
          sum_r    <= $signed(ram_rdata.sum);
          cnt_r    <= ram_rdata.cnt;
        end else begin
          peak_r   <= '0;
          valley_r <= '0;
          sum_r    <= '0;
          cnt_r    <= '0;
        end
      end
      OP_PMUL, OP_VMUL: begin
        prod_r <= prod_full;
      end
      OP_PADD: begin
        peak_r <= track_new;
      end
      OP_VADD: begin
        valley_r <= track_new;
      end
      OP_LEVEL: begin
        level_r <= lvl_clamp;
      end
      OP_DECIM: begin
        if (status.decim_hit) begin
          sum_r    <= '0;
          cnt_r    <= '0;
          hit_r    <= 1'b1;
          div_neg  <= sum_new[SUM_W-1];
          div_quot <= sum_mag;
          div_rem  <= '0;
          div_cnt  <= '0;
        end else begin
          sum_r <= sum_new;
          cnt_r <= cnt_new;
        end
      end
      OP_DIV: begin
        div_rem  <= trial_ge ? trial[FACTOR_W-1:0] : rem_sh[FACTOR_W-1:0];
        div_quot <= {div_quot[SUM_W-2:0], trial_ge};
        div_cnt  <= div_cnt + DIV_CNT_W'(1);
      end
      OP_EMIT: begin
        em_cnt <= em_cnt + EM_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written_r <= '0;
    end else if (cmd.op == OP_WRITE) begin
      written_r[idx_r] <= 1'b1;
    end
  end

  // Output register: loaded only when empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_sample_valid   <= res_valid;
      out_demod_sample   <= res_sample;
      out_received_level <= level_r;
      out_last_of_run    <= emit_last;
    end
  end

endmodule
`default_nettype wire

@@ rtl/audio_frontend_level_decimate.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// audio_frontend_level_decimate
// Per-stream peak/valley level tracker with boxcar decimation or zero-stuff
// upsampling of the demodulator sample feed.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch carries one item per audio sample: a stream index and a signed
//   16-bit sample. result_ch returns the results of that item, in order; the
//   final one has last_of_run set. Off and AFSK modes give one result per
//   item, baseband gives UPSAMPLE_FACTOR results.
//   The APB port holds the mode, decimation factor and the two tracker
//   coefficients; write them only while no item is in flight.
//   Items are handled one at a time: a new item is taken only once the
//   last result of the one before is loaded into the output register.
//   AFSK mode takes longer than off mode when the factor is above one,
//   and longer still when an average is due, as the bit-serial divider
//   then works through all 20 bits of the sum; baseband takes longer as
//   UPSAMPLE_FACTOR grows. The state memory read, the shared tracker
//   multiplier and the divider set the time an item takes.
//   Reset clears the registers to their defaults and marks every stream's
//   state as zero at once; no clearing pass is needed.
//   A stalled receiver holds the output register; the block waits with the
//   next result and still takes a new item once the last one is loaded.
// ----------------------------------------------------------------------------
module audio_frontend_level_decimate #(
  parameter int NUM_STREAMS     = afld_pkg::DEF_NUM_STREAMS,
  parameter int UPSAMPLE_FACTOR = afld_pkg::DEF_UPSAMPLE_FACTOR
) (
  input  logic                              clk,
  input  logic                              rst,
  afld_in_if.sink                           sample_ch,
  afld_out_if.source                        result_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [afld_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [afld_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [afld_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import afld_pkg::*;

  localparam int IDX_W = idx_width(NUM_STREAMS);

  cfg_t          cfg;
  dp_cmd_t       cmd;
  dp_status_t    status;
  logic          ram_we;
  logic [IDX_W-1:0] ram_addr;
  state_word_t   ram_wdata;
  state_word_t   ram_rdata;

  afld_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  afld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (sample_ch.valid),
    .in_ready (sample_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  afld_dp #(
    .NUM_STREAMS     (NUM_STREAMS),
    .UPSAMPLE_FACTOR (UPSAMPLE_FACTOR)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .cmd                (cmd),
    .in_stream_index    (sample_ch.stream_index),
    .in_audio_sample    (sample_ch.audio_sample),
    .status             (status),
    .ram_we             (ram_we),
    .ram_addr           (ram_addr),
    .ram_wdata          (ram_wdata),
    .ram_rdata          (ram_rdata),
    .out_ready          (result_ch.ready),
    .out_valid          (result_ch.valid),
    .out_sample_valid   (result_ch.sample_valid),
    .out_demod_sample   (result_ch.demod_sample),
    .out_received_level (result_ch.received_level),
    .out_last_of_run    (result_ch.last_of_run)
  );

  afld_ram #(
    .WIDTH ($bits(state_word_t)),
    .DEPTH (NUM_STREAMS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

@@ rtl/afld_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afld_checker
// Port-level checks on the item channels, bound to the top level.
// ----------------------------------------------------------------------------
module afld_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic                                 sample_valid,
  input logic signed [afld_pkg::DEMOD_W-1:0]  demod_sample,
  input logic [afld_pkg::LEVEL_W-1:0]         received_level,
  input logic                                 last_of_run
);
  import afld_pkg::*;

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // Items are worked one at a time: no second accept right after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in progress");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> received_level <= LEVEL_W'(LEVEL_MAX))
    else $error("received level above clamp");

  a_idle_sample_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sample_valid |-> demod_sample == '0)
    else $error("demod sample not zero on a non-sample result");

  // Only the stuffed zeros of baseband come before the last result.
  a_stuffed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> sample_valid && demod_sample == '0)
    else $error("non-final result is not a stuffed zero");

endmodule

bind audio_frontend_level_decimate afld_checker u_afld_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (sample_ch.valid),
  .in_ready       (sample_ch.ready),
  .out_valid      (result_ch.valid),
  .out_ready      (result_ch.ready),
  .sample_valid   (result_ch.sample_valid),
  .demod_sample   (result_ch.demod_sample),
  .received_level (result_ch.received_level),
  .last_of_run    (result_ch.last_of_run)
);
`default_nettype wire
